>>> rtl/core/i2cms_pkg.sv
package i2cms_pkg;

  localparam logic [2:0] CMD_IDLE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_READ  = 3'd3;
  localparam logic [2:0] CMD_STOP  = 3'd4;

  localparam logic [2:0] PHASE_A    = 3'd0;
  localparam logic [2:0] PHASE_B    = 3'd1;
  localparam logic [2:0] PHASE_C    = 3'd2;
  localparam logic [2:0] BYTE_LOW   = 3'd3;
  localparam logic [2:0] BYTE_HIGH  = 3'd4;

  localparam logic [3:0] LAST_SLOT  = 4'd8;
  localparam logic [3:0] LAST_DATA  = 4'd7;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd1000;

  typedef struct packed {
    logic [2:0] op;
    logic [6:0] target_addr;
    logic       read_request;
    logic [7:0] write_data;
    logic       master_nack;
    logic       sda_in;
  } i2cms_req_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic       ack_seen;
    logic [7:0] read_data;
  } i2cms_res_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic drv;
  } i2cms_pins_t;

endpackage

>>> rtl/core/i2c_master_bit_sequencer_unit.sv
// A request's result is registered, in the skid register when the output stalls.
// Throughput: one request per cycle while the skid is free; each is one bus tick with one result.
// A two-entry output stage (result register plus skid register) decouples the sides.
// Reset (rst, synchronous, active high) idles the sequencer, releases SCL and SDA high,
// and sets the half period to 1000 ticks.
module i2c_master_bit_sequencer_unit
  import i2cms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  i2cms_req_t  in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output i2cms_res_t  out_data
);

  logic [15:0] half_period;
  logic [2:0]  command;
  logic [2:0]  phase;
  logic [3:0]  bit_index;
  logic [8:0]  shifter;
  logic [15:0] divider;
  logic        scl_reg;
  logic        sda_reg;
  logic        drv_reg;
  logic        ack_flag;
  logic [7:0]  rx_byte;

  logic [2:0]  command_next;
  logic [2:0]  phase_next;
  logic [3:0]  bit_index_next;
  logic [8:0]  shifter_next;
  logic [15:0] divider_next;
  logic        ack_flag_next;
  logic [7:0]  rx_byte_next;
  i2cms_pins_t pins_next;
  logic        done;

  logic        skid_valid;
  i2cms_res_t  skid_data;
  i2cms_res_t  result;
  logic        in_accept;
  logic        out_take;

  function automatic i2cms_pins_t show_segment(logic [2:0] cmd, logic [2:0] ph,
                                               logic [3:0] idx, logic top);
    i2cms_pins_t p;
    logic        d;
    if (ph == BYTE_LOW || ph == BYTE_HIGH) begin
      d = (cmd == CMD_READ) ? (idx == LAST_SLOT) : (idx < LAST_SLOT);
      p.scl = (ph == BYTE_HIGH);
      p.sda = d ? top : 1'b1;
      p.drv = d;
    end else if (cmd == CMD_START) begin
      p.scl = (ph != PHASE_A);
      p.sda = (ph != PHASE_C);
      p.drv = 1'b1;
    end else begin
      p.scl = (ph != PHASE_A);
      p.sda = (ph == PHASE_C);
      p.drv = 1'b1;
    end
    return p;
  endfunction

  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  always_comb begin
    logic [15:0] limit;
    logic [15:0] count;
    logic        fin;
    logic        show;
    command_next   = command;
    phase_next     = phase;
    bit_index_next = bit_index;
    shifter_next   = shifter;
    divider_next   = divider;
    ack_flag_next  = ack_flag;
    rx_byte_next   = rx_byte;
    fin            = 1'b0;
    show           = 1'b0;
    limit          = (half_period == 16'd0) ? 16'd1 : half_period;
    count          = divider + 16'd1;
    if (command == CMD_IDLE) begin
      if (in_data.op inside {[CMD_START:CMD_STOP]}) begin
        command_next   = in_data.op;
        phase_next     = PHASE_A;
        bit_index_next = 4'd0;
        divider_next   = 16'd0;
        show           = 1'b1;
        case (in_data.op)
          CMD_START: shifter_next = {in_data.target_addr, in_data.read_request, 1'b1};
          CMD_WRITE: begin
            shifter_next = {in_data.write_data, 1'b1};
            phase_next   = BYTE_LOW;
          end
          CMD_READ: begin
            shifter_next = {8'd0, in_data.master_nack};
            phase_next   = BYTE_LOW;
          end
          default: shifter_next = 9'd0;
        endcase
      end
    end else if (count >= limit) begin
      divider_next = 16'd0;
      if (phase == BYTE_LOW) begin
        phase_next = BYTE_HIGH;
      end else if (phase == BYTE_HIGH) begin
        if (command == CMD_READ) begin
          if (bit_index < LAST_SLOT) begin
            shifter_next = {shifter[7:0], in_data.sda_in};
            if (bit_index == LAST_DATA) begin
              rx_byte_next = {shifter[6:0], in_data.sda_in};
            end
          end
        end else if (bit_index == LAST_SLOT) begin
          ack_flag_next = !in_data.sda_in;
        end else begin
          shifter_next = {shifter[7:0], 1'b0};
        end
        if (bit_index >= LAST_SLOT) begin
          fin = 1'b1;
        end else begin
          bit_index_next = bit_index + 4'd1;
          phase_next     = BYTE_LOW;
        end
      end else if (phase < PHASE_C) begin
        phase_next = phase + 3'd1;
      end else if (command == CMD_START) begin
        phase_next     = BYTE_LOW;
        bit_index_next = 4'd0;
      end else begin
        fin = 1'b1;
      end
      if (fin) begin
        command_next   = CMD_IDLE;
        phase_next     = PHASE_A;
        bit_index_next = 4'd0;
      end else begin
        show = 1'b1;
      end
    end else begin
      divider_next = count;
    end
    done = fin;
    if (show) begin
      pins_next = show_segment(command_next, phase_next, bit_index_next, shifter_next[8]);
    end else begin
      pins_next = '{scl: scl_reg, sda: sda_reg, drv: drv_reg};
    end
  end

  always_comb begin
    result.scl_level = pins_next.scl;
    result.sda_level = pins_next.sda;
    result.sda_drive = pins_next.drv;
    result.busy_res  = (command_next != CMD_IDLE);
    result.done_res  = done;
    result.ack_seen  = ack_flag_next;
    result.read_data = rx_byte_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_PERIOD_RESET;
    end else if (cfg_write_en) begin
      half_period <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command   <= CMD_IDLE;
      phase     <= PHASE_A;
      bit_index <= 4'd0;
      shifter   <= 9'd0;
      divider   <= 16'd0;
      scl_reg   <= 1'b1;
      sda_reg   <= 1'b1;
      drv_reg   <= 1'b1;
      ack_flag  <= 1'b0;
      rx_byte   <= 8'd0;
    end else if (in_accept) begin
      command   <= command_next;
      phase     <= phase_next;
      bit_index <= bit_index_next;
      shifter   <= shifter_next;
      divider   <= divider_next;
      scl_reg   <= pins_next.scl;
      sda_reg   <= pins_next.sda;
      drv_reg   <= pins_next.drv;
      ack_flag  <= ack_flag_next;
      rx_byte   <= rx_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= in_accept;
      end else begin
        out_valid <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_data  <= skid_data;
        skid_data <= result;
      end else begin
        out_data <= result;
      end
    end else if (in_accept) begin
      skid_data <= result;
    end
  end

`ifndef SYNTH
  // The skid register only fills behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while the output register is empty");

  // An idle sequencer always sits at the first phase with a cleared bit counter.
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (command == CMD_IDLE) |-> (phase == PHASE_A && bit_index == 4'd0))
    else $error("idle sequencer holds a stale phase or bit index");

  // The bit counter never runs past the acknowledge slot.
  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_index <= LAST_SLOT)
    else $error("bit index beyond the acknowledge slot");

  // A completed command leaves the sequencer idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (in_accept && done) |=> (command == CMD_IDLE))
    else $error("sequencer still busy after reporting done");
`endif

endmodule
